// File: src/v6p_pkg.sv
// Shared types and constants for the IPv6 text address parser.
// No dependencies.
`timescale 1ns / 1ps
package v6p_pkg;
  localparam int unsigned MaxTextChars = 45;
  localparam int unsigned QueueDepth = 2;

  localparam logic [2:0] PhStart = 3'd0;
  localparam logic [2:0] PhLead = 3'd1;
  localparam logic [2:0] PhAfterGap = 3'd2;
  localparam logic [2:0] PhAfterColon = 3'd3;
  localparam logic [2:0] PhHex = 3'd4;
  localparam logic [2:0] PhQuad = 3'd5;

  localparam logic [7:0] ChColon = 8'h3a;
  localparam logic [7:0] ChDot = 8'h2e;

  typedef enum logic [2:0] {
    CLS_DEC, CLS_HEX_AF, CLS_COLON, CLS_DOT, CLS_OTHER
  } char_cls_e;

  // Classified character as handed from the front to the back.
  typedef struct packed {
    char_cls_e  cls;
    logic [3:0] digit;
    logic       too_long;
    logic       last;
  } char_tok_t;
endpackage

// File: src/v6p_front.sv
// Front end: accepts characters, classifies them and counts string length.
// Depends on v6p_pkg.
`timescale 1ns / 1ps
module v6p_front #(
  parameter int unsigned MaxChars = v6p_pkg::MaxTextChars
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic [7:0]          text_char_i,
  input  logic                is_last_i,
  output logic                tok_valid_o,
  input  logic                tok_ready_i,
  output v6p_pkg::char_tok_t  tok_o
);
  logic [7:0] count_q, count_d;
  logic       acc;

  assign ready_o     = tok_ready_i;
  assign tok_valid_o = valid_i;
  assign acc         = valid_i && tok_ready_i;

  always_comb begin
    tok_o.last     = is_last_i;
    tok_o.too_long = ({24'd0, count_q} >= MaxChars);
    tok_o.digit    = 4'd0;
    tok_o.cls      = v6p_pkg::CLS_OTHER;
    if (text_char_i >= 8'h30 && text_char_i <= 8'h39) begin
      tok_o.cls   = v6p_pkg::CLS_DEC;
      tok_o.digit = 4'(text_char_i - 8'h30);
    end else if (text_char_i >= 8'h61 && text_char_i <= 8'h66) begin
      tok_o.cls   = v6p_pkg::CLS_HEX_AF;
      tok_o.digit = 4'(text_char_i - 8'h57);
    end else if (text_char_i >= 8'h41 && text_char_i <= 8'h46) begin
      tok_o.cls   = v6p_pkg::CLS_HEX_AF;
      tok_o.digit = 4'(text_char_i - 8'h37);
    end else if (text_char_i == v6p_pkg::ChColon) begin
      tok_o.cls = v6p_pkg::CLS_COLON;
    end else if (text_char_i == v6p_pkg::ChDot) begin
      tok_o.cls = v6p_pkg::CLS_DOT;
    end
  end

  always_comb begin
    count_d = count_q;
    if (acc) begin
      if (is_last_i) count_d = 8'd0;
      else if (count_q != 8'hff) count_d = count_q + 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 8'd0;
    end else begin
      count_q <= count_d;
    end
  end
endmodule

// File: src/v6p_queue.sv
// Small FIFO of classified characters between front and back.
// Depends on v6p_pkg.
`timescale 1ns / 1ps
module v6p_queue #(
  parameter int unsigned Depth = v6p_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_valid_i,
  output logic               wr_ready_o,
  input  v6p_pkg::char_tok_t wr_data_i,
  output logic               rd_valid_o,
  input  logic               rd_ready_i,
  output v6p_pkg::char_tok_t rd_data_o
);
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;
  v6p_pkg::char_tok_t   mem_q [Depth];
  logic [Aw-1:0]        wp_q, rp_q;
  logic [Aw:0]          cnt_q;
  logic                 wr, rd;

  assign wr_ready_o = (cnt_q != (Aw+1)'(Depth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= (wp_q == Aw'(Depth - 1)) ? '0 : wp_q + 1'b1;
      if (rd) rp_q <= (rp_q == Aw'(Depth - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (Aw+1)'(wr) - (Aw+1)'(rd);
    end
  end
endmodule

// File: src/v6p_back.sv
// Back end: grammar state machine, group collection and result register.
// Depends on v6p_pkg.
`timescale 1ns / 1ps
module v6p_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               tok_valid_i,
  output logic               tok_ready_o,
  input  v6p_pkg::char_tok_t tok_i,
  output logic               valid_o,
  input  logic               ready_i,
  output logic               address_valid_o,
  output logic [15:0]        group_o [8]
);
  logic [15:0] grp_q [8];
  logic [15:0] grp_d [8];
  logic [3:0]  gcnt_q, gcnt_d, gpos_q, gpos_d;
  logic        gap_q, gap_d, err_q, err_d, lz_q, lz_d, nd_q, nd_d;
  logic [15:0] hex_q, hex_d;
  logic [9:0]  dec_q, dec_d;
  logic [2:0]  dcnt_q, dcnt_d, ph_q, ph_d;
  logic [7:0]  qb_q [3];
  logic [7:0]  qb_d [3];
  logic [1:0]  qi_q, qi_d;
  logic        ovalid_q, oaddr_q, oaddr_d;
  logic [15:0] ogrp_q [8];
  logic [15:0] ogrp_d [8];
  logic        acc, is_dig, is_dec, octet_ok, ok;
  logic [3:0]  gtot, zeros;
  logic [15:0] fin [8];
  logic [9:0]  dec_mul;

  assign tok_ready_o = !ovalid_q || ready_i;
  assign acc    = tok_valid_i && tok_ready_o;
  assign is_dec = (tok_i.cls == v6p_pkg::CLS_DEC);
  assign is_dig = is_dec || (tok_i.cls == v6p_pkg::CLS_HEX_AF);
  assign octet_ok = (dcnt_q != 3'd0) && (dec_q <= 10'd255) && !(dcnt_q > 3'd1 && lz_q);
  assign dec_mul = 10'((dec_q << 3) + (dec_q << 1) + {6'd0, is_dec ? tok_i.digit : 4'd0});

  always_comb begin
    logic bad, qbad;
    logic [3:0] zi;
    grp_d = grp_q; gcnt_d = gcnt_q; gap_d = gap_q; gpos_d = gpos_q;
    hex_d = hex_q; dec_d = dec_q; dcnt_d = dcnt_q; lz_d = lz_q; nd_d = nd_q;
    ph_d = ph_q; qb_d = qb_q; qi_d = qi_q; err_d = err_q | tok_i.too_long;
    bad = 1'b0;
    if (!err_d) begin
      unique case (ph_q)
        v6p_pkg::PhStart, v6p_pkg::PhAfterGap, v6p_pkg::PhAfterColon: begin
          if (tok_i.cls == v6p_pkg::CLS_COLON && ph_q == v6p_pkg::PhStart) begin
            ph_d = v6p_pkg::PhLead;
          end else if (tok_i.cls == v6p_pkg::CLS_COLON && ph_q == v6p_pkg::PhAfterColon) begin
            if (gap_q) bad = 1'b1;
            else begin
              gap_d = 1'b1; gpos_d = gcnt_q; ph_d = v6p_pkg::PhAfterGap;
            end
          end else if (is_dig) begin
            if (gcnt_q >= 4'd8) bad = 1'b1;
            else begin
              hex_d = {12'd0, tok_i.digit};
              dec_d = is_dec ? {6'd0, tok_i.digit} : 10'd0;
              dcnt_d = 3'd1; lz_d = (tok_i.digit == 4'd0); nd_d = !is_dec;
              ph_d = v6p_pkg::PhHex;
            end
          end else bad = 1'b1;
        end
        v6p_pkg::PhLead: begin
          if (tok_i.cls == v6p_pkg::CLS_COLON) begin
            gap_d = 1'b1; gpos_d = 4'd0; ph_d = v6p_pkg::PhAfterGap;
          end else bad = 1'b1;
        end
        v6p_pkg::PhHex: begin
          if (is_dig) begin
            if (dcnt_q >= 3'd4) bad = 1'b1;
            else begin
              hex_d = {hex_q[11:0], tok_i.digit};
              if (!is_dec) nd_d = 1'b1;
              if (dcnt_q < 3'd3) dec_d = dec_mul;
              dcnt_d = dcnt_q + 3'd1;
            end
          end else if (tok_i.cls == v6p_pkg::CLS_COLON) begin
            if (gcnt_q < 4'd8) begin
              grp_d[gcnt_q[2:0]] = hex_q; gcnt_d = gcnt_q + 4'd1;
            end else bad = 1'b1;
            ph_d = v6p_pkg::PhAfterColon;
          end else if (tok_i.cls == v6p_pkg::CLS_DOT) begin
            if (gcnt_q > 4'd6 || dcnt_q > 3'd3 || nd_q || !octet_ok) bad = 1'b1;
            else begin
              qb_d[0] = dec_q[7:0]; qi_d = 2'd1; dcnt_d = 3'd0; dec_d = 10'd0;
              lz_d = 1'b0; ph_d = v6p_pkg::PhQuad;
            end
          end else bad = 1'b1;
        end
        v6p_pkg::PhQuad: begin
          if (is_dec) begin
            if (dcnt_q >= 3'd3) bad = 1'b1;
            else begin
              if (dcnt_q == 3'd0) lz_d = (tok_i.digit == 4'd0);
              dec_d = dec_mul; dcnt_d = dcnt_q + 3'd1;
            end
          end else if (tok_i.cls == v6p_pkg::CLS_DOT) begin
            if (qi_q >= 2'd3 || !octet_ok) bad = 1'b1;
            else begin
              qb_d[qi_q] = dec_q[7:0]; qi_d = qi_q + 2'd1;
              dcnt_d = 3'd0; dec_d = 10'd0; lz_d = 1'b0;
            end
          end else bad = 1'b1;
        end
        default: bad = 1'b1;
      endcase
    end
    err_d = err_d | bad;

    // Finish from the updated state.
    ok = !err_d;
    gtot = gcnt_d;
    fin = grp_d;
    qbad = (qi_d != 2'd3) || (dcnt_d == 3'd0) || (dec_d > 10'd255)
           || (dcnt_d > 3'd1 && lz_d) || (gcnt_d > 4'd6);
    if (ok) begin
      if (ph_d == v6p_pkg::PhHex) begin
        if (gcnt_d < 4'd8) begin
          fin[gcnt_d[2:0]] = hex_d; gtot = gcnt_d + 4'd1;
        end else ok = 1'b0;
      end else if (ph_d == v6p_pkg::PhQuad) begin
        if (qbad) ok = 1'b0;
        else begin
          fin[gcnt_d[2:0]] = {qb_d[0], qb_d[1]};
          fin[3'(gcnt_d + 4'd1)] = {qb_d[2], dec_d[7:0]};
          gtot = gcnt_d + 4'd2;
        end
      end else if (ph_d != v6p_pkg::PhAfterGap) ok = 1'b0;
    end
    if (ok) begin
      if (gap_d) begin
        if (gtot > 4'd7 || gpos_d > gtot) ok = 1'b0;
      end else if (gtot != 4'd8) ok = 1'b0;
    end
    zeros = 4'd8 - gtot;
    oaddr_d = ok;
    for (int i = 0; i < 8; i++) begin
      zi = 4'(i);
      if (!ok) ogrp_d[i] = 16'd0;
      else if (!gap_d || zi < gpos_d) ogrp_d[i] = fin[i];
      else if ({1'b0, zi} < {1'b0, gpos_d} + {1'b0, zeros}) ogrp_d[i] = 16'd0;
      else ogrp_d[i] = fin[3'(zi - zeros)];
    end
  end

  assign valid_o = ovalid_q;
  assign address_valid_o = oaddr_q;
  assign group_o = ogrp_q;

  always_ff @(posedge clk_i) begin
    if (acc && tok_i.last) begin
      oaddr_q <= oaddr_d;
      ogrp_q  <= ogrp_d;
    end
    if (acc && !tok_i.last) begin
      qb_q <= qb_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
      for (int i = 0; i < 8; i++) grp_q[i] <= 16'd0;
      gcnt_q <= '0; gap_q <= 1'b0; gpos_q <= '0; hex_q <= '0; dec_q <= '0;
      dcnt_q <= '0; lz_q <= 1'b0; nd_q <= 1'b0; ph_q <= v6p_pkg::PhStart;
      qi_q <= '0; err_q <= 1'b0;
    end else begin
      if (ready_i) ovalid_q <= 1'b0;
      if (acc) begin
        if (tok_i.last) begin
          ovalid_q <= 1'b1;
          for (int i = 0; i < 8; i++) grp_q[i] <= 16'd0;
          gcnt_q <= '0; gap_q <= 1'b0; gpos_q <= '0; hex_q <= '0; dec_q <= '0;
          dcnt_q <= '0; lz_q <= 1'b0; nd_q <= 1'b0; ph_q <= v6p_pkg::PhStart;
          qi_q <= '0; err_q <= 1'b0;
        end else begin
          grp_q <= grp_d; gcnt_q <= gcnt_d; gap_q <= gap_d; gpos_q <= gpos_d;
          hex_q <= hex_d; dec_q <= dec_d; dcnt_q <= dcnt_d; lz_q <= lz_d;
          nd_q <= nd_d; ph_q <= ph_d; qi_q <= qi_d; err_q <= err_d;
        end
      end
    end
  end
endmodule

// File: src/ipv6_text_address_parser.sv
// IPv6 text address parser, one character per cycle unless the result stalls.
// Result path: the last character is written into the queue when accepted, and
// the back end then takes it into the result register unless a stalled result
// holds it back. Throughput: one character per cycle unless the result stalls,
// set by the grammar update in the back end. Reset: asynchronous, active low;
// clears the queue and the parse state but for the dotted-quad byte store.
`timescale 1ns / 1ps
module ipv6_text_address_parser #(
  parameter int unsigned MaxTextChars = v6p_pkg::MaxTextChars
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [7:0]  text_char_i,
  input  logic        is_last_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic        address_valid_o,
  output logic [15:0] group_0_o,
  output logic [15:0] group_1_o,
  output logic [15:0] group_2_o,
  output logic [15:0] group_3_o,
  output logic [15:0] group_4_o,
  output logic [15:0] group_5_o,
  output logic [15:0] group_6_o,
  output logic [15:0] group_7_o
);
  v6p_pkg::char_tok_t ftok, qtok;
  logic fv, fr, qv, qr;
  logic [15:0] grp [8];

  v6p_front #(.MaxChars(MaxTextChars)) u_front (
    .clk_i, .rst_ni, .valid_i, .ready_o, .text_char_i, .is_last_i,
    .tok_valid_o(fv), .tok_ready_i(fr), .tok_o(ftok)
  );

  v6p_queue #(.Depth(v6p_pkg::QueueDepth)) u_queue (
    .clk_i, .rst_ni, .wr_valid_i(fv), .wr_ready_o(fr), .wr_data_i(ftok),
    .rd_valid_o(qv), .rd_ready_i(qr), .rd_data_o(qtok)
  );

  v6p_back u_back (
    .clk_i, .rst_ni, .tok_valid_i(qv), .tok_ready_o(qr), .tok_i(qtok),
    .valid_o, .ready_i, .address_valid_o, .group_o(grp)
  );

  assign group_0_o = grp[0];
  assign group_1_o = grp[1];
  assign group_2_o = grp[2];
  assign group_3_o = grp[3];
  assign group_4_o = grp[4];
  assign group_5_o = grp[5];
  assign group_6_o = grp[6];
  assign group_7_o = grp[7];
endmodule

// File: src/v6p_checker.sv
// Port-level checks for the IPv6 text address parser, bound to the top level.
// Depends on ipv6_text_address_parser.
`timescale 1ns / 1ps
module v6p_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_o,
  input logic        ready_i,
  input logic        address_valid_o,
  input logic [15:0] group_0_o,
  input logic [15:0] group_7_o
);
  // An invalid result carries all-zero groups; groups 0 and 7 are checked.
  a_zero_inv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !address_valid_o) |-> (group_0_o == 16'd0 && group_7_o == 16'd0))
    else $error("invalid result with non-zero groups");

  // A stalled result holds; valid, address_valid and group 0 are checked.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !ready_i) |=> (valid_o && $stable(address_valid_o) && $stable(group_0_o)))
    else $error("stalled result changed");

  // No result straight out of reset.
  a_rst: assert property (@(posedge clk_i) !rst_ni |=> !valid_o)
    else $error("result valid after reset");
endmodule

bind ipv6_text_address_parser v6p_checker u_v6p_checker (
  .clk_i, .rst_ni, .valid_o, .ready_i, .address_valid_o, .group_0_o, .group_7_o
);
